// ----- design/clock_time_set_controller_assert.svh -----
// Assertion macros for the time-set controller.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CLOCK_TIME_SET_CONTROLLER_ASSERT_SVH
`define CLOCK_TIME_SET_CONTROLLER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CLKTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define CLKTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/clkts_pkg.sv -----
package clkts_pkg;

    // Debouncer history constants
    localparam logic [15:0] HIST_FORCE = 16'hE000;
    localparam logic [15:0] HIST_PRESS = 16'hF000;

    // Hour register layout
    localparam int HOUR_12_BIT = 6;
    localparam int PM_BIT      = 5;

    // Externally visible mode codes
    localparam logic [1:0] SET_MODE_IDLE   = 2'd0;
    localparam logic [1:0] SET_MODE_MINUTE = 2'd1;
    localparam logic [1:0] SET_MODE_HOUR   = 2'd2;

    typedef struct packed {
        logic       set_button_level;
        logic       inc_button_level;
        logic       clock_read_valid;
        logic [6:0] clock_minute_in;
        logic [6:0] clock_hour_in;
    } clkts_scan_t;

    typedef struct packed {
        logic [3:0] minute_ones;
        logic [2:0] minute_tens;
        logic [3:0] hour_ones;
        logic [1:0] hour_tens;
        logic       hour_tens_shown;
        logic       pm_lamp;
        logic       colon_lamp;
        logic [1:0] set_mode;
        logic       clock_write;
        logic [6:0] write_minute;
        logic [6:0] write_hour;
    } clkts_result_t;

endpackage

// ----- design/clock_time_set_controller.sv -----
// Two-button clock time-set controller.
// Input channel scan/scan_valid/scan_ready carries one scan per transfer:
// raw set and increment button levels plus an optional clock reading.
// Output channel result/result_valid/result_ready returns exactly one
// result per scan: display digits, lamps, the set mode and a clock write
// request with the minute and hour register values to write.
// From the input transfer to result_valid, the scan waits in the input
// register, then the button debouncers and time logic run in a single
// pass into the result register. Throughput is one scan per cycle while
// the receiver does not stall; the state update is a single pass of
// short BCD logic, so scans may follow back to back.
// When the receiver stalls, the result register holds and the input
// register takes one more scan; scan_ready then drops until the stall ends.
// Reset clears both registers' valid flags, the debounce histories, the
// time to 00:00 in 24-hour form, the mode to idle and sets the colon on.
module clock_time_set_controller
    import clkts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          scan_valid,
    output logic          scan_ready,
    input  clkts_scan_t   scan,
    output logic          result_valid,
    input  logic          result_ready,
    output clkts_result_t result
);

`include "clock_time_set_controller_assert.svh"

    clkts_scan_t   scan_reg;
    logic          scan_valid_reg;
    clkts_result_t result_reg;
    logic          result_valid_reg;
    clkts_result_t core_result;
    logic          advance;
    logic          set_press;
    logic          inc_press;

    // Move the held scan into the result register when there is room
    assign advance    = scan_valid_reg & (~result_valid_reg | result_ready);
    assign scan_ready = ~scan_valid_reg | advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    clkts_debounce u_set_debounce (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .level (scan_reg.set_button_level),
        .press (set_press)
    );

    clkts_debounce u_inc_debounce (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .level (scan_reg.inc_button_level),
        .press (inc_press)
    );

    clkts_time u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .set_press (set_press),
        .inc_press (inc_press),
        .scan      (scan_reg),
        .result    (core_result)
    );

    // Capture a new scan on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
        end
        else if (scan_valid && scan_ready)
        begin
            scan_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            scan_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && scan_ready)
        begin
            scan_reg <= scan;
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    `CLKTS_ASSERT(a_write_in_idle, !(result_valid_reg && result_reg.clock_write) || (result_reg.set_mode == SET_MODE_IDLE), "clock write outside idle mode")
    `CLKTS_ASSERT(a_write_zero, !result_valid_reg || result_reg.clock_write || ((result_reg.write_minute == 7'd0) && (result_reg.write_hour == 7'd0)), "write fields not zero without clock write")
    `CLKTS_ASSERT_NEXT(a_advance_fills, advance, result_valid_reg, "processed scan produced no result")
    `CLKTS_ASSERT_NEXT(a_scan_held, scan_valid_reg && !advance, scan_valid_reg, "held scan dropped")

endmodule

// ----- design/clkts_debounce.sv -----
module clkts_debounce
    import clkts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic level,
    output logic press
);

    logic [15:0] hist_reg;
    logic [15:0] hist_next;

    // Shift in the new sample, forcing the top bits high
    assign hist_next = {hist_reg[14:0], level} | HIST_FORCE;
    // Fire on one released sample followed by twelve pressed samples
    assign press = (hist_next == HIST_PRESS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (step)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

// ----- design/clkts_time.sv -----
module clkts_time
    import clkts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          set_press,
    input  logic          inc_press,
    input  clkts_scan_t   scan,
    output clkts_result_t result
);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_MINUTE = 3'b010,
        MODE_HOUR   = 3'b100
    } mode_t;

    mode_t      mode_reg,   mode_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] hour_reg,   hour_next;
    logic       twelve_reg, twelve_next;
    logic       colon_reg,  colon_next;
    logic       write_now;

    // Binary 0..59 to packed BCD
    function automatic logic [6:0] to_bcd(input logic [5:0] v);
        logic [2:0] t;
        logic [5:0] r;
        if (v >= 6'd50)
        begin
            t = 3'd5;
            r = v - 6'd50;
        end
        else if (v >= 6'd40)
        begin
            t = 3'd4;
            r = v - 6'd40;
        end
        else if (v >= 6'd30)
        begin
            t = 3'd3;
            r = v - 6'd30;
        end
        else if (v >= 6'd20)
        begin
            t = 3'd2;
            r = v - 6'd20;
        end
        else if (v >= 6'd10)
        begin
            t = 3'd1;
            r = v - 6'd10;
        end
        else
        begin
            t = 3'd0;
            r = v;
        end
        return {t, r[3:0]};
    endfunction

    // Minute register to binary, wrapped modulo 60
    function automatic logic [5:0] minute_mod60(input logic [6:0] bcd);
        logic [6:0] v;
        v = 7'(bcd[6:4]) * 7'd10 + 7'(bcd[3:0]);
        return (v >= 7'd60) ? 6'(v - 7'd60) : v[5:0];
    endfunction

    // 12-hour register to binary, wrapped modulo 12
    function automatic logic [3:0] hour12_mod12(input logic [6:0] bcd);
        logic [4:0] v;
        v = 5'(bcd[4]) * 5'd10 + 5'(bcd[3:0]);
        if (v >= 5'd24)
        begin
            v = v - 5'd24;
        end
        else if (v >= 5'd12)
        begin
            v = v - 5'd12;
        end
        return v[3:0];
    endfunction

    // 24-hour register to binary, wrapped modulo 24
    function automatic logic [4:0] hour24_mod24(input logic [6:0] bcd);
        logic [5:0] v;
        v = 6'(bcd[5:4]) * 6'd10 + 6'(bcd[3:0]);
        return (v >= 6'd24) ? 5'(v - 6'd24) : v[4:0];
    endfunction

    // Build a 12-hour register from hour 1..12 and PM flag
    function automatic logic [6:0] make_hour12(input logic [3:0] h, input logic pm);
        logic [6:0] b;
        b = to_bcd(6'(h));
        return {1'b1, pm, b[4:0]};
    endfunction

    // Build a 24-hour register from hour 0..23
    function automatic logic [6:0] make_hour24(input logic [4:0] h);
        logic [6:0] b;
        b = to_bcd(6'(h));
        return {1'b0, b[5:0]};
    endfunction

    // Apply set press, increment press and reading in that order
    always_comb
    begin
        logic [3:0] h12;
        logic [4:0] h24;
        logic [5:0] mbin;
        logic [1:0] tens;
        logic       pm;

        mode_next   = mode_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        twelve_next = twelve_reg;
        colon_next  = colon_reg;
        write_now   = 1'b0;
        h12         = '0;
        h24         = '0;
        mbin        = '0;
        pm          = 1'b0;

        if (set_press)
        begin
            case (mode_reg)
                MODE_MINUTE: mode_next = MODE_HOUR;
                MODE_HOUR:
                begin
                    mode_next = MODE_IDLE;
                    write_now = 1'b1;
                end
                default:     mode_next = MODE_MINUTE;
            endcase
        end

        if (inc_press)
        begin
            case (mode_next)
                MODE_MINUTE:
                begin
                    // Advance the minutes, wrapping 59 to 00
                    mbin = minute_mod60(minute_reg);
                    mbin = (mbin == 6'd59) ? 6'd0 : mbin + 6'd1;
                    minute_next = to_bcd(mbin);
                end
                MODE_HOUR:
                begin
                    if (twelve_reg)
                    begin
                        pm  = hour_reg[PM_BIT];
                        h12 = hour12_mod12(hour_reg) + 4'd1;
                        if (h12 == 4'd12)
                        begin
                            pm = ~pm;
                        end
                        hour_next = make_hour12(h12, pm);
                    end
                    else
                    begin
                        h24 = hour24_mod24(hour_reg);
                        h24 = (h24 == 5'd23) ? 5'd0 : h24 + 5'd1;
                        hour_next = make_hour24(h24);
                    end
                end
                default:
                begin
                    // Convert between 12-hour and 24-hour form and write it out
                    if (twelve_reg)
                    begin
                        h24 = 5'(hour12_mod12(hour_reg));
                        if (hour_reg[PM_BIT])
                        begin
                            h24 = h24 + 5'd12;
                        end
                        hour_next   = make_hour24(h24);
                        twelve_next = 1'b0;
                    end
                    else
                    begin
                        h24 = hour24_mod24(hour_reg);
                        pm  = (h24 >= 5'd12);
                        h12 = pm ? 4'(h24 - 5'd12) : h24[3:0];
                        if (h12 == 4'd0)
                        begin
                            h12 = 4'd12;
                        end
                        hour_next   = make_hour12(h12, pm);
                        twelve_next = 1'b1;
                    end
                    write_now = 1'b1;
                end
            endcase
        end

        // Take a reading only while idle
        if (scan.clock_read_valid && (mode_next == MODE_IDLE))
        begin
            minute_next = to_bcd(minute_mod60(scan.clock_minute_in));
            if (scan.clock_hour_in[HOUR_12_BIT])
            begin
                h12 = hour12_mod12(scan.clock_hour_in);
                if (h12 == 4'd0)
                begin
                    h12 = 4'd12;
                end
                hour_next   = make_hour12(h12, scan.clock_hour_in[PM_BIT]);
                twelve_next = 1'b1;
            end
            else
            begin
                hour_next   = make_hour24(hour24_mod24(scan.clock_hour_in));
                twelve_next = 1'b0;
            end
            colon_next = ~colon_reg;
        end

        // Decode the display from the updated state
        tens = twelve_next ? {1'b0, hour_next[4]} : hour_next[5:4];

        result.minute_ones     = minute_next[3:0];
        result.minute_tens     = minute_next[6:4];
        result.hour_ones       = hour_next[3:0];
        result.hour_tens       = tens;
        result.hour_tens_shown = (tens != 2'd0);
        result.pm_lamp         = twelve_next & hour_next[PM_BIT];
        result.colon_lamp      = colon_next;
        case (mode_next)
            MODE_MINUTE: result.set_mode = SET_MODE_MINUTE;
            MODE_HOUR:   result.set_mode = SET_MODE_HOUR;
            default:     result.set_mode = SET_MODE_IDLE;
        endcase
        result.clock_write  = write_now;
        result.write_minute = write_now ? minute_next : 7'd0;
        result.write_hour   = write_now ? hour_next : 7'd0;
    end

    // Commit state once per processed scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            minute_reg <= '0;
            hour_reg   <= '0;
            twelve_reg <= 1'b0;
            colon_reg  <= 1'b1;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            minute_reg <= minute_next;
            hour_reg   <= hour_next;
            twelve_reg <= twelve_next;
            colon_reg  <= colon_next;
        end
    end

endmodule
